>>> sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// opcodes and status codes of the priority thread scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_ADD       = 3'd1,
        OP_KILL      = 3'd2,
        OP_SLEEP     = 3'd3,
        OP_ADD_EVENT = 3'd4,
        OP_BLOCK     = 3'd5,
        OP_SCHEDULE  = 3'd6,
        OP_NOP       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_TABLE_FULL = 3'd1,
        STAT_KILL_LAST  = 3'd2,
        STAT_NO_THREAD  = 3'd3,
        STAT_EVENT_FULL = 3'd4
    } status_t;

    localparam int PRIO_W  = 8;
    localparam int SLEEP_W = 32;
    localparam int TIME_W  = 32;

endpackage

>>> sv/priority_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// priority_thread_scheduler_unit
// priority thread scheduler with a table of periodic events
// ----------------------------------------------------------------------------
//  channel   | ports                                             | handshake
//  ----------+---------------------------------------------------+----------------
//  command   | opcode thread_id priority_req duration period     | start & !busy
//            | start_time block_flag                             |
//  result    | status thread_slot none_ready event_fired         | done, one cycle
//            | event_index thread_count                          |
//
//  add, add event, set blocked and nop finish straight from idle; sleep
//  passes a read wait; kill a read wait and a slot scan; schedule a slot scan;
//  tick a scan of max(THREAD_SLOTS,EVENT_SLOTS) entries; one slot record per
//  cycle through the slot memory read port, read-modify-write one entry behind
//  reset is immediate: alive, blocked and asleep flags live in flops and clear
//  at once; record and event memories are only read where written before
//  the result beat cannot be held off; the next command may start in the
//  same cycle as the done beat
// ----------------------------------------------------------------------------
module priority_thread_scheduler_unit
    import pts_pkg::*;
#(
    parameter int THREAD_SLOTS = 16,
    parameter int EVENT_SLOTS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [3:0]  thread_id,
    input  logic [7:0]  priority_req,
    input  logic [31:0] duration,
    input  logic [31:0] period,
    input  logic [31:0] start_time,
    input  logic        block_flag,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  thread_slot,
    output logic        none_ready,
    output logic        event_fired,
    output logic [2:0]  event_index,
    output logic [4:0]  thread_count
);

    localparam int TW   = $clog2(THREAD_SLOTS);
    localparam int EW   = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CW   = $clog2(THREAD_SLOTS + 1);
    localparam int ECW  = $clog2(EVENT_SLOTS + 1);
    localparam int MAXS = (THREAD_SLOTS > EVENT_SLOTS) ? THREAD_SLOTS : EVENT_SLOTS;
    localparam int SW   = $clog2(MAXS + 1);
    // slot record: priority, age rank, sleep countdown
    localparam int RW   = PRIO_W + TW + SLEEP_W;
    // event record: interval, due time
    localparam int EVW  = 2 * TIME_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_KILL_WAIT,
        S_SLEEP_WAIT,
        S_SCAN
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [SLEEP_W-1:0]   dur_reg, dur_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [TW-1:0]        cur_reg, cur_next;
    logic [CW-1:0]        live_reg, live_next;
    logic [ECW-1:0]       evcnt_reg, evcnt_next;
    logic [THREAD_SLOTS-1:0] alive_reg, alive_next;
    logic [THREAD_SLOTS-1:0] blocked_reg, blocked_next;
    logic [THREAD_SLOTS-1:0] asleep_reg, asleep_next;

    // scan pipeline
    logic [SW-1:0]        scan_reg, scan_next;
    logic [SW-1:0]        lim_reg, lim_next;
    logic                 pvld_reg, pvld_next;
    logic [SW-1:0]        pidx_reg, pidx_next;
    logic [TW-1:0]        krank_reg, krank_next;
    logic                 found_reg, found_next;
    logic [PRIO_W-1:0]    bprio_reg, bprio_next;
    logic [TW-1:0]        brank_reg, brank_next;
    logic [TW-1:0]        bidx_reg, bidx_next;

    // result beat
    logic                 done_reg, done_next;
    status_t              stat_reg, stat_next;
    logic [TW-1:0]        slot_reg, slot_next;
    logic                 none_reg, none_next;
    logic                 fired_reg, fired_next;
    logic [EW-1:0]        eidx_reg, eidx_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    // memory ports
    logic                 t_we;
    logic [TW-1:0]        t_waddr, t_raddr;
    logic [RW-1:0]        t_wdata, t_rdata;
    logic                 e_we;
    logic [EW-1:0]        e_waddr, e_raddr;
    logic [EVW-1:0]       e_wdata, e_rdata;

    logic                 accept;
    logic [6:0]           tid_ext;
    logic                 tid_ok;
    logic [TW-1:0]        tid_idx;
    logic [TW-1:0]        free_idx;
    logic [TW-1:0]        pi;
    logic                 p_thr, p_evt;
    logic [PRIO_W-1:0]    r_prio;
    logic [TW-1:0]        r_rank;
    logic [SLEEP_W-1:0]   r_sleep;
    logic [SLEEP_W-1:0]   sleep_dec;
    logic [TIME_W-1:0]    r_ivl, r_due;
    logic [6:0]           slot_ext;
    logic [6:0]           cnt_ext;
    logic [4:0]           eidx_ext;

    pts_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(RW), .AW(TW)) u_slot_ram
    (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    pts_ram #(.DEPTH(EVENT_SLOTS), .WIDTH(EVW), .AW(EW)) u_event_ram
    (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    // slot named by the command port, checked against the table size
    assign tid_ext = {3'b000, thread_id};
    assign tid_ok  = (tid_ext < 7'(THREAD_SLOTS));
    assign tid_idx = tid_ext[TW-1:0];

    // record fields of the beat read last cycle
    assign r_prio    = t_rdata[RW-1 -: PRIO_W];
    assign r_rank    = t_rdata[SLEEP_W +: TW];
    assign r_sleep   = t_rdata[SLEEP_W-1:0];
    assign sleep_dec = r_sleep - SLEEP_W'(1);
    assign r_ivl     = e_rdata[EVW-1 -: TIME_W];
    assign r_due     = e_rdata[TIME_W-1:0];

    assign pi    = pidx_reg[TW-1:0];
    assign p_thr = (pidx_reg < SW'(THREAD_SLOTS));
    assign p_evt = (pidx_reg < SW'(evcnt_reg));

    // lowest dead slot
    always_comb
    begin
        free_idx = '0;
        for (int i = THREAD_SLOTS - 1; i >= 0; i--)
        begin
            if (!alive_reg[i])
            begin
                free_idx = TW'(i);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        dur_next     = dur_reg;
        time_next    = time_reg;
        cur_next     = cur_reg;
        live_next    = live_reg;
        evcnt_next   = evcnt_reg;
        alive_next   = alive_reg;
        blocked_next = blocked_reg;
        asleep_next  = asleep_reg;
        scan_next    = scan_reg;
        lim_next     = lim_reg;
        pvld_next    = 1'b0;
        pidx_next    = pidx_reg;
        krank_next   = krank_reg;
        found_next   = found_reg;
        bprio_next   = bprio_reg;
        brank_next   = brank_reg;
        bidx_next    = bidx_reg;
        done_next    = 1'b0;
        stat_next    = stat_reg;
        slot_next    = slot_reg;
        none_next    = none_reg;
        fired_next   = fired_reg;
        eidx_next    = eidx_reg;
        cnt_next     = cnt_reg;
        t_we         = 1'b0;
        t_waddr      = pi;
        t_wdata      = '0;
        t_raddr      = scan_reg[TW-1:0];
        e_we         = 1'b0;
        e_waddr      = pidx_reg[EW-1:0];
        e_wdata      = '0;
        e_raddr      = scan_reg[EW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(opcode);
                    dur_next   = duration;
                    stat_next  = STAT_OK;
                    slot_next  = '0;
                    none_next  = 1'b0;
                    fired_next = 1'b0;
                    eidx_next  = '0;
                    scan_next  = '0;
                    lim_next   = SW'(THREAD_SLOTS);
                    found_next = 1'b0;
                    unique case (op_t'(opcode))
                        OP_TICK:
                        begin
                            time_next  = time_reg + TIME_W'(1);
                            lim_next   = SW'(MAXS);
                            state_next = S_SCAN;
                        end
                        OP_ADD:
                        begin
                            done_next = 1'b1;
                            if (live_reg >= CW'(THREAD_SLOTS))
                            begin
                                stat_next = STAT_TABLE_FULL;
                            end
                            else
                            begin
                                alive_next[free_idx]   = 1'b1;
                                blocked_next[free_idx] = 1'b0;
                                asleep_next[free_idx]  = 1'b0;
                                t_we      = 1'b1;
                                t_waddr   = free_idx;
                                t_wdata   = {priority_req, live_reg[TW-1:0], SLEEP_W'(0)};
                                live_next = live_reg + CW'(1);
                                slot_next = free_idx;
                            end
                        end
                        OP_KILL:
                        begin
                            // decode the slot straight from the port
                            if (live_reg == CW'(1))
                            begin
                                stat_next = STAT_KILL_LAST;
                                done_next = 1'b1;
                            end
                            else if (!tid_ok || !alive_reg[tid_idx])
                            begin
                                stat_next = STAT_NO_THREAD;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                alive_next[tid_idx]   = 1'b0;
                                blocked_next[tid_idx] = 1'b0;
                                asleep_next[tid_idx]  = 1'b0;
                                live_next  = live_reg - CW'(1);
                                t_raddr    = tid_idx;
                                state_next = S_KILL_WAIT;
                            end
                        end
                        OP_SLEEP:
                        begin
                            if (!alive_reg[cur_reg])
                            begin
                                stat_next = STAT_NO_THREAD;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                t_raddr    = cur_reg;
                                state_next = S_SLEEP_WAIT;
                            end
                        end
                        OP_ADD_EVENT:
                        begin
                            done_next = 1'b1;
                            if (evcnt_reg >= ECW'(EVENT_SLOTS))
                            begin
                                stat_next = STAT_EVENT_FULL;
                            end
                            else
                            begin
                                e_we       = 1'b1;
                                e_waddr    = evcnt_reg[EW-1:0];
                                e_wdata    = {period, start_time};
                                eidx_next  = evcnt_reg[EW-1:0];
                                evcnt_next = evcnt_reg + ECW'(1);
                            end
                        end
                        OP_BLOCK:
                        begin
                            done_next = 1'b1;
                            if (!tid_ok || !alive_reg[tid_idx])
                            begin
                                stat_next = STAT_NO_THREAD;
                            end
                            else
                            begin
                                blocked_next[tid_idx] = block_flag;
                            end
                        end
                        OP_SCHEDULE:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_NOP:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_KILL_WAIT:
            begin
                krank_next = r_rank;
                state_next = S_SCAN;
            end
            S_SLEEP_WAIT:
            begin
                t_we    = 1'b1;
                t_waddr = cur_reg;
                t_wdata = {r_prio, r_rank, dur_reg};
                asleep_next[cur_reg] = (dur_reg != '0);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                // issue the next read
                if (scan_reg < lim_reg)
                begin
                    pvld_next = 1'b1;
                    pidx_next = scan_reg;
                    scan_next = scan_reg + SW'(1);
                end
                // modify and write back the entry read last cycle
                if (pvld_reg)
                begin
                    case (op_reg)
                        OP_TICK:
                        begin
                            if (p_thr && asleep_reg[pi])
                            begin
                                t_we    = 1'b1;
                                t_wdata = {r_prio, r_rank, sleep_dec};
                                if (sleep_dec == '0)
                                begin
                                    asleep_next[pi] = 1'b0;
                                end
                            end
                            if (p_evt && !found_reg && (r_due == time_reg))
                            begin
                                e_we       = 1'b1;
                                e_wdata    = {r_ivl, r_due + r_ivl};
                                found_next = 1'b1;
                                fired_next = 1'b1;
                                eidx_next  = pidx_reg[EW-1:0];
                            end
                        end
                        OP_KILL:
                        begin
                            if (p_thr && alive_reg[pi] && (r_rank > krank_reg))
                            begin
                                t_we    = 1'b1;
                                t_wdata = {r_prio, r_rank - TW'(1), r_sleep};
                            end
                        end
                        default:
                        begin
                            if (p_thr && alive_reg[pi] && !blocked_reg[pi] &&
                                !asleep_reg[pi])
                            begin
                                if (!found_reg || (r_prio < bprio_reg) ||
                                    ((r_prio == bprio_reg) && (r_rank < brank_reg)))
                                begin
                                    found_next = 1'b1;
                                    bprio_next = r_prio;
                                    brank_next = r_rank;
                                    bidx_next  = pi;
                                end
                            end
                        end
                    endcase
                end
                else if (scan_reg == lim_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_SCHEDULE)
                    begin
                        if (found_reg)
                        begin
                            cur_next  = bidx_reg;
                            slot_next = bidx_reg;
                        end
                        else
                        begin
                            none_next = 1'b1;
                        end
                    end
                end
            end
        endcase

        if (done_next)
        begin
            cnt_next = live_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_NOP;
            dur_reg     <= '0;
            time_reg    <= '0;
            cur_reg     <= '0;
            live_reg    <= '0;
            evcnt_reg   <= '0;
            alive_reg   <= '0;
            blocked_reg <= '0;
            asleep_reg  <= '0;
            scan_reg    <= '0;
            lim_reg     <= '0;
            pvld_reg    <= 1'b0;
            pidx_reg    <= '0;
            krank_reg   <= '0;
            found_reg   <= 1'b0;
            bprio_reg   <= '0;
            brank_reg   <= '0;
            bidx_reg    <= '0;
            done_reg    <= 1'b0;
            stat_reg    <= STAT_OK;
            slot_reg    <= '0;
            none_reg    <= 1'b0;
            fired_reg   <= 1'b0;
            eidx_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            dur_reg     <= dur_next;
            time_reg    <= time_next;
            cur_reg     <= cur_next;
            live_reg    <= live_next;
            evcnt_reg   <= evcnt_next;
            alive_reg   <= alive_next;
            blocked_reg <= blocked_next;
            asleep_reg  <= asleep_next;
            scan_reg    <= scan_next;
            lim_reg     <= lim_next;
            pvld_reg    <= pvld_next;
            pidx_reg    <= pidx_next;
            krank_reg   <= krank_next;
            found_reg   <= found_next;
            bprio_reg   <= bprio_next;
            brank_reg   <= brank_next;
            bidx_reg    <= bidx_next;
            done_reg    <= done_next;
            stat_reg    <= stat_next;
            slot_reg    <= slot_next;
            none_reg    <= none_next;
            fired_reg   <= fired_next;
            eidx_reg    <= eidx_next;
            cnt_reg     <= cnt_next;
        end
    end

    // result beat, widened or trimmed to the port widths
    assign slot_ext     = 7'(slot_reg);
    assign cnt_ext      = 7'(cnt_reg);
    assign eidx_ext     = 5'(eidx_reg);
    assign done         = done_reg;
    assign status       = stat_reg;
    assign thread_slot  = slot_ext[3:0];
    assign none_ready   = none_reg;
    assign event_fired  = fired_reg;
    assign event_index  = eidx_ext[2:0];
    assign thread_count = cnt_ext[4:0];

    // live count tracks the alive flags
    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(alive_reg) == 32'(live_reg))
        else $error("live count out of step with alive flags");

    // the scan pipeline only runs inside a scan
    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pvld_reg |-> (state_reg == S_SCAN))
        else $error("scan stage valid outside a scan");

    // a result beat always leaves the block ready for a command
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result beat while busy");

    // no eligible thread reports slot zero
    a_none_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && none_reg) |-> (slot_reg == '0))
        else $error("slot set with none ready");

endmodule

>>> sv/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module pts_ram
    import pts_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int WIDTH = PRIO_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
